[rtl/core/sorq_pkg.sv]
package sorq_pkg;

  // Request codes carried on req_type
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_CYCLE  = 1'b1;

  // Request broadcast to every cell in the row
  typedef struct packed {
    logic ins;  // insert the new word by speed
    logic cyc;  // rotate the front entry to the tail
  } sorq_cmd_t;

  // Where a cell sits relative to the current fill level
  typedef struct packed {
    logic below;     // index < count, cell holds a live entry
    logic at_count;  // index == count, first free slot
    logic at_last;   // index == count - 1, current tail
  } sorq_pos_t;

endpackage

[rtl/core/speed_ordered_rotating_queue_top.sv]
// Speed-ordered rotating queue.
// Input channel (in_valid / in_stall) takes one request word: req_type,
// entry_id, entry_speed. An insert places the entry ahead of the first held
// entry with a strictly lower speed (ties keep arrival order); a cycle moves
// the front entry to the tail. Output channel (out_valid / out_stall) gives
// exactly one result word per request: front entry, occupancy, drop flag.
// Latency: the result is registered, out_valid rises the cycle after the
// request is accepted. Throughput: one request per cycle; every cell
// compares its key against the new speed and shifts in the same cycle, the
// carry of the "slower entry found" flag running down the row of cells.
// Stall: while out_valid is high and out_stall is asserted the result holds
// and in_stall is raised, so no request is taken until the word leaves.
// Reset (rst, synchronous): the list is emptied and no result is pending.
// Slot contents are not cleared; only slots below the count are ever read.
// An insert into a full list leaves it untouched and sets insert_dropped.
module speed_ordered_rotating_queue_top #(
  parameter int DEPTH      = 16,
  parameter int SPEED_BITS = 8,
  parameter int ID_BITS    = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [ID_BITS-1:0]             entry_id,
  input  logic [SPEED_BITS-1:0]          entry_speed,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           front_valid,
  output logic [ID_BITS-1:0]             front_id,
  output logic [SPEED_BITS-1:0]          front_speed,
  output logic [$clog2(DEPTH+1)-1:0]     occupancy,
  output logic                           insert_dropped
);
  import sorq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  sorq_cmd_t        cmd;

  // per-cell data, as held and as it will be after this edge
  logic [ID_BITS-1:0]    cell_id         [DEPTH];
  logic [SPEED_BITS-1:0] cell_speed      [DEPTH];
  logic [ID_BITS-1:0]    cell_id_next    [DEPTH];
  logic [SPEED_BITS-1:0] cell_speed_next [DEPTH];
  logic [DEPTH:0]        found;  // found[i] feeds cell i

  // output register frees the input whenever it is empty or being drained
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = (count == CNT_W'(DEPTH));

  assign cmd.ins = accept && (req_type == REQ_INSERT) && !full;
  assign cmd.cyc = accept && (req_type == REQ_CYCLE) && (count != '0);

  assign count_next = count + CNT_W'(cmd.ins);
  assign found[0]   = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sorq_pos_t             pos;
    logic [ID_BITS-1:0]    prev_id;
    logic [SPEED_BITS-1:0] prev_speed;
    logic [ID_BITS-1:0]    next_id;
    logic [SPEED_BITS-1:0] next_speed;

    assign pos.below    = CNT_W'(i) < count;
    assign pos.at_count = count == CNT_W'(i);
    assign pos.at_last  = count == CNT_W'(i + 1);

    // front cell never shifts from behind; tail cell never pulls from ahead
    if (i == 0) begin : g_head
      assign prev_id    = entry_id;
      assign prev_speed = entry_speed;
    end else begin : g_body
      assign prev_id    = cell_id[i-1];
      assign prev_speed = cell_speed[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign next_id    = cell_id[0];
      assign next_speed = cell_speed[0];
    end else begin : g_link
      assign next_id    = cell_id[i+1];
      assign next_speed = cell_speed[i+1];
    end

    sorq_cell #(
      .ID_BITS    (ID_BITS),
      .SPEED_BITS (SPEED_BITS)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .new_id     (entry_id),
      .new_speed  (entry_speed),
      .prev_id    (prev_id),
      .prev_speed (prev_speed),
      .next_id    (next_id),
      .next_speed (next_speed),
      .head_id    (cell_id[0]),
      .head_speed (cell_speed[0]),
      .id         (cell_id[i]),
      .speed      (cell_speed[i]),
      .id_next    (cell_id_next[i]),
      .speed_next (cell_speed_next[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload: front entry as it stands after the request
  always_ff @(posedge clk) begin
    if (accept) begin
      front_valid    <= (count_next != '0);
      front_id       <= (count_next != '0) ? cell_id_next[0] : '0;
      front_speed    <= (count_next != '0) ? cell_speed_next[0] : '0;
      occupancy      <= count_next;
      insert_dropped <= (req_type == REQ_INSERT) && full;
    end
  end

endmodule

[rtl/core/sorq_cell.sv]
module sorq_cell #(
  parameter int ID_BITS    = 8,
  parameter int SPEED_BITS = 8
) (
  input  logic                  clk,
  input  sorq_pkg::sorq_cmd_t   cmd,
  input  sorq_pkg::sorq_pos_t   pos,
  input  logic                  found_in,
  output logic                  found_out,
  input  logic [ID_BITS-1:0]    new_id,
  input  logic [SPEED_BITS-1:0] new_speed,
  input  logic [ID_BITS-1:0]    prev_id,
  input  logic [SPEED_BITS-1:0] prev_speed,
  input  logic [ID_BITS-1:0]    next_id,
  input  logic [SPEED_BITS-1:0] next_speed,
  input  logic [ID_BITS-1:0]    head_id,
  input  logic [SPEED_BITS-1:0] head_speed,
  output logic [ID_BITS-1:0]    id,
  output logic [SPEED_BITS-1:0] speed,
  output logic [ID_BITS-1:0]    id_next,
  output logic [SPEED_BITS-1:0] speed_next
);
  import sorq_pkg::*;

  logic beats;

  // live entry strictly slower than the new word
  assign beats     = pos.below && (new_speed > speed);
  assign found_out = found_in | beats;

  always_comb begin
    id_next    = id;
    speed_next = speed;
    if (cmd.ins) begin
      if (found_in) begin
        id_next    = prev_id;
        speed_next = prev_speed;
      end else if (beats || pos.at_count) begin
        id_next    = new_id;
        speed_next = new_speed;
      end
    end else if (cmd.cyc) begin
      if (pos.at_last) begin
        id_next    = head_id;
        speed_next = head_speed;
      end else if (pos.below) begin
        id_next    = next_id;
        speed_next = next_speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    id    <= id_next;
    speed <= speed_next;
  end

endmodule

[rtl/core/sorq_checker.sv]
module sorq_checker #(
  parameter int DEPTH      = 16,
  parameter int SPEED_BITS = 8,
  parameter int ID_BITS    = 8
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       req_type,
  input logic [ID_BITS-1:0]         entry_id,
  input logic [SPEED_BITS-1:0]      entry_speed,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       front_valid,
  input logic [ID_BITS-1:0]         front_id,
  input logic [SPEED_BITS-1:0]      front_speed,
  input logic [$clog2(DEPTH+1)-1:0] occupancy,
  input logic                       insert_dropped
);
  import sorq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(occupancy) && $stable(front_id)
      && $stable(front_speed) && $stable(insert_dropped))
    else $error("result word changed under stall");

  // every accepted request yields a result word next cycle
  a_resp: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request gave no result");

  // front flag agrees with occupancy, never above the depth
  a_front: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (front_valid == (occupancy != '0)) && (occupancy <= CNT_W'(DEPTH)))
    else $error("front flag or occupancy inconsistent");

  // a drop only when the list is full and the request was an insert
  a_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (req_type == REQ_INSERT) ##1 out_valid && insert_dropped
      |-> occupancy == CNT_W'(DEPTH))
    else $error("insert dropped while list not full");

  // empty list reports a zeroed front entry and no drop
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !front_valid |-> (front_id == '0) && (front_speed == '0)
      && !insert_dropped)
    else $error("empty list shows a front entry");

endmodule

bind speed_ordered_rotating_queue_top sorq_checker #(
  .DEPTH      (DEPTH),
  .SPEED_BITS (SPEED_BITS),
  .ID_BITS    (ID_BITS)
) u_sorq_checker (.*);
